// ===== design/ring_resource_pair_arbiter_defines.svh =====
// Assertion macros shared by the ring resource pair arbiter.
`ifndef RING_RESOURCE_PAIR_ARBITER_DEFINES_SVH
`define RING_RESOURCE_PAIR_ARBITER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define RRPA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define RRPA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/rrpa_pkg.sv =====
// Types and constants shared by the ring resource pair arbiter modules.
package rrpa_pkg;

	localparam int SEAT_W     = 3;
	localparam int CNT_W      = 4;
	localparam int DATA_W     = 8;
	localparam int FIFO_DEPTH = 2;

	localparam logic [CNT_W-1:0] MIN_RING      = 4'd2;
	// A ring needs at least three seats before a seat has two distinct neighbors.
	localparam logic [CNT_W-1:0] MIN_PAIR_RING = 4'd3;
	localparam logic [CNT_W-1:0] RESET_SEATS   = 4'd5;

	localparam logic VERDICT_GRANT  = 1'b0;
	localparam logic VERDICT_REFUSE = 1'b1;

	typedef enum logic [1:0] {
		MODE_REQUEST   = 2'd0,
		MODE_RELEASE   = 2'd1,
		MODE_TERMINATE = 2'd2
	} mode_t;

	typedef struct packed {
		mode_t              kind;
		logic [SEAT_W-1:0]  seat;
	} cmd_t;

	typedef struct packed {
		logic              scanning;
		logic              terminating;
		logic              terminated;
		logic [CNT_W-1:0]  wait_count;
	} status_t;

endpackage

// ===== design/rrpa_front.sv =====
// Front end: accepts input items and passes on only the commands that can have an effect.
module rrpa_front import rrpa_pkg::*; (
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [2:0] seat, rest zero
	input  logic [1:0]        s_tuser,   // [1:0] mode
	input  logic [CNT_W-1:0]  ring_n,
	input  logic              fifo_full,
	output logic              push,
	output cmd_t              push_cmd
);

	logic [SEAT_W-1:0] seat;
	logic              in_range;
	logic              keep;

	assign seat     = s_tdata[SEAT_W-1:0];
	assign in_range = CNT_W'(seat) < ring_n;
	assign s_tready = !fifo_full;

	always_comb begin
		keep          = 1'b0;
		push_cmd.kind = MODE_REQUEST;
		push_cmd.seat = seat;
		case (s_tuser)
			MODE_REQUEST: begin
				keep          = in_range;
				push_cmd.kind = MODE_REQUEST;
			end
			MODE_RELEASE: begin
				keep          = in_range;
				push_cmd.kind = MODE_RELEASE;
			end
			MODE_TERMINATE: begin
				keep          = 1'b1;
				push_cmd.kind = MODE_TERMINATE;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = s_tvalid && s_tready && keep;

endmodule

// ===== design/rrpa_cmd_fifo.sv =====
// Short command queue between the front end and the arbitration engine.
module rrpa_cmd_fifo import rrpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic clr,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic pop_valid,
	output cmd_t pop_cmd
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_FW = $clog2(FIFO_DEPTH + 1);

	cmd_t              mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_FW-1:0] cnt_q;

	assign full      = cnt_q == CNT_FW'(FIFO_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else if (clr) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/rrpa_back.sv =====
// Arbitration engine: wait queue, resource state, release scan and terminate walk.
module rrpa_back import rrpa_pkg::*; #(
	parameter int MAX_SEATS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic [CNT_W-1:0]  ring_n,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SEAT_W-1:0] out_seat,
	output logic              out_verdict,
	output logic              out_last,
	output status_t           status
);

	localparam int RING_MAX = (MAX_SEATS < 15) ? MAX_SEATS : 15;
	localparam int QDEPTH   = (MAX_SEATS < 8) ? MAX_SEATS : 8;
	localparam int RES_W    = $clog2(RING_MAX);
	localparam int QIDX_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_TERM = 3'b100
	} state_t;

	state_t             state_q;
	logic [QCNT_W-1:0]  idx_q;
	logic [QCNT_W-1:0]  count_q;
	logic [QDEPTH-1:0]  queued_q;
	logic [QDEPTH-1:0]  holding_q;
	logic [RING_MAX-1:0] busy_q;
	logic               term_q;
	logic               pend_valid_q;
	logic [SEAT_W-1:0]  pend_seat_q;
	logic [SEAT_W-1:0]  queue_q [QDEPTH];
	logic               out_valid_q;
	logic [SEAT_W-1:0]  out_seat_q;
	logic               out_verdict_q;
	logic               out_last_q;

	logic              out_free;
	logic              idx_in_range;
	logic [SEAT_W-1:0] scan_seat;
	logic [SEAT_W-1:0] chk_seat;
	logic [CNT_W-1:0]  seat_ext;
	logic [CNT_W-1:0]  up_ext;
	logic [CNT_W-1:0]  up_seat;
	logic [CNT_W-1:0]  down_seat;
	logic              up_queued;
	logic              down_queued;
	logic              res_free;
	logic              near_pair;
	logic              at_front;
	logic              can_take;
	logic              dup;
	logic              q_full;
	logic              term_last;
	logic              q_append;
	logic              q_remove;
	logic              out_load;
	logic [SEAT_W-1:0] out_seat_d;
	logic              out_verdict_d;
	logic              out_last_d;

	assign out_free     = !out_valid_q || out_ready;
	assign idx_in_range = idx_q < count_q;
	assign scan_seat    = queue_q[QIDX_W'(idx_q)];
	assign chk_seat     = (state_q == ST_IDLE) ? cmd.seat : scan_seat;

	// Ring neighbors of the seat under check; the right resource is the up neighbor.
	assign seat_ext  = CNT_W'(chk_seat);
	assign up_ext    = seat_ext + 1'b1;
	assign up_seat   = (up_ext == ring_n) ? '0 : up_ext;
	assign down_seat = (seat_ext == '0) ? ring_n - 1'b1 : seat_ext - 1'b1;

	assign up_queued   = (int'(up_seat) < QDEPTH) && queued_q[QIDX_W'(up_seat)];
	assign down_queued = (int'(down_seat) < QDEPTH) && queued_q[QIDX_W'(down_seat)];
	assign res_free    = !busy_q[RES_W'(chk_seat)] && !busy_q[RES_W'(up_seat)];
	assign near_pair   = up_queued && down_queued && (ring_n >= MIN_PAIR_RING);
	// Seats in the queue are distinct, so the front test reduces to a position test.
	assign at_front    = (state_q == ST_IDLE) ? (count_q == '0) : (idx_q == '0);
	assign can_take    = res_free && (at_front || near_pair);

	assign dup       = holding_q[QIDX_W'(cmd.seat)] || queued_q[QIDX_W'(cmd.seat)];
	assign q_full    = count_q == QCNT_W'(QDEPTH);
	assign term_last = idx_q == (count_q - 1'b1);

	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid && out_free && !clr;
	assign q_append = cmd_pop && (cmd.kind == MODE_REQUEST) && !dup && !term_q
		&& !q_full && !can_take;
	assign q_remove = (state_q == ST_SCAN) && idx_in_range && can_take
		&& (!pend_valid_q || out_free);

	always_comb begin
		out_load      = 1'b0;
		out_seat_d    = chk_seat;
		out_verdict_d = VERDICT_GRANT;
		out_last_d    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (cmd_pop && (cmd.kind == MODE_REQUEST) && !dup) begin
					if (term_q) begin
						out_load      = 1'b1;
						out_verdict_d = VERDICT_REFUSE;
					end else if (!q_full && can_take) begin
						out_load = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				// A grant stays pending until the scan shows whether another follows it.
				if (idx_in_range) begin
					if (q_remove && pend_valid_q) begin
						out_load   = 1'b1;
						out_seat_d = pend_seat_q;
						out_last_d = 1'b0;
					end
				end else if (pend_valid_q && out_free) begin
					out_load   = 1'b1;
					out_seat_d = pend_seat_q;
				end
			end
			ST_TERM: begin
				if (out_free && idx_in_range) begin
					out_load      = 1'b1;
					out_seat_d    = scan_seat;
					out_verdict_d = VERDICT_REFUSE;
					out_last_d    = term_last;
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_append) begin
			queue_q[QIDX_W'(count_q)] <= cmd.seat;
		end else if (q_remove) begin
			for (int j = 0; j < QDEPTH - 1; j++) begin
				if (QCNT_W'(j) >= idx_q) begin
					queue_q[j] <= queue_q[j+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			idx_q         <= '0;
			count_q       <= '0;
			queued_q      <= '0;
			holding_q     <= '0;
			busy_q        <= '0;
			term_q        <= 1'b0;
			pend_valid_q  <= 1'b0;
			pend_seat_q   <= '0;
			out_valid_q   <= 1'b0;
			out_seat_q    <= '0;
			out_verdict_q <= VERDICT_GRANT;
			out_last_q    <= 1'b0;
		end else if (clr) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			count_q      <= '0;
			queued_q     <= '0;
			holding_q    <= '0;
			busy_q       <= '0;
			term_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q   <= 1'b1;
				out_seat_q    <= out_seat_d;
				out_verdict_q <= out_verdict_d;
				out_last_q    <= out_last_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						case (cmd.kind)
							MODE_REQUEST: begin
								if (!dup && !term_q && !q_full) begin
									if (can_take) begin
										busy_q[RES_W'(chk_seat)]     <= 1'b1;
										busy_q[RES_W'(up_seat)]      <= 1'b1;
										holding_q[QIDX_W'(chk_seat)] <= 1'b1;
									end else begin
										queued_q[QIDX_W'(chk_seat)] <= 1'b1;
										count_q                     <= count_q + 1'b1;
									end
								end
							end
							MODE_RELEASE: begin
								if (holding_q[QIDX_W'(chk_seat)]) begin
									holding_q[QIDX_W'(chk_seat)] <= 1'b0;
									busy_q[RES_W'(chk_seat)]     <= 1'b0;
									busy_q[RES_W'(up_seat)]      <= 1'b0;
									if (!term_q) begin
										state_q      <= ST_SCAN;
										idx_q        <= '0;
										pend_valid_q <= 1'b0;
									end
								end
							end
							MODE_TERMINATE: begin
								term_q <= 1'b1;
								if (count_q != '0) begin
									state_q <= ST_TERM;
									idx_q   <= '0;
								end
							end
							default: begin
								term_q <= term_q;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (idx_in_range) begin
						if (can_take) begin
							// A granted entry leaves the queue; the index then points at its successor.
							if (q_remove) begin
								pend_valid_q                 <= 1'b1;
								pend_seat_q                  <= scan_seat;
								busy_q[RES_W'(chk_seat)]     <= 1'b1;
								busy_q[RES_W'(up_seat)]      <= 1'b1;
								holding_q[QIDX_W'(chk_seat)] <= 1'b1;
								queued_q[QIDX_W'(chk_seat)]  <= 1'b0;
								count_q                      <= count_q - 1'b1;
							end
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				ST_TERM: begin
					if (out_free) begin
						if (term_last) begin
							count_q  <= '0;
							queued_q <= '0;
							state_q  <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_seat    = out_seat_q;
	assign out_verdict = out_verdict_q;
	assign out_last    = out_last_q;

	assign status.scanning    = state_q == ST_SCAN;
	assign status.terminating = state_q == ST_TERM;
	assign status.terminated  = term_q;
	assign status.wait_count  = CNT_W'(count_q);

endmodule

// ===== design/ring_resource_pair_arbiter.sv =====
// A request's result passes the command queue and the output register; a terminate's first
// refusal also passes the terminate walk state. A release holds the engine while its serial
// queue scan checks the waiters and sets the release rate; terminate holds it for its walk.
// Requests sustain one item per cycle while the engine is idle and the output is not stalled.
// Reset (arst_n low, asynchronous) sets seat_count to 5, frees all resources and empties the
// queue; a seat_count write clears the same state and keeps the written value.
`include "ring_resource_pair_arbiter_defines.svh"

module ring_resource_pair_arbiter import rrpa_pkg::*; #(
	parameter int MAX_SEATS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data,    // [3:0] seat_count
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,     // [2:0] seat, [7:3] zero
	input  logic [1:0]        s_tuser,     // [1:0] mode
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,     // [2:0] granted_seat, [7:3] zero
	output logic              m_tuser,     // [0] verdict
	output logic              m_tlast
);

	logic [CNT_W-1:0]  seat_count_q;
	logic [CNT_W-1:0]  ring_n;
	logic              clr;
	logic              fifo_full;
	logic              push;
	cmd_t              push_cmd;
	logic              pop;
	logic              pop_valid;
	cmd_t              pop_cmd;
	logic [SEAT_W-1:0] out_seat;
	status_t           status;

	assign cfg_ready = 1'b1;
	assign clr       = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seat_count_q <= RESET_SEATS;
		end else if (clr) begin
			seat_count_q <= cfg_data;
		end
	end

	always_comb begin
		if (seat_count_q < MIN_RING) begin
			ring_n = MIN_RING;
		end else if (int'(seat_count_q) > MAX_SEATS) begin
			ring_n = CNT_W'(MAX_SEATS);
		end else begin
			ring_n = seat_count_q;
		end
	end

	rrpa_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.ring_n    (ring_n),
		.fifo_full (fifo_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	rrpa_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (clr),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (fifo_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_cmd   (pop_cmd)
	);

	rrpa_back #(
		.MAX_SEATS (MAX_SEATS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.clr         (clr),
		.ring_n      (ring_n),
		.cmd_valid   (pop_valid),
		.cmd         (pop_cmd),
		.cmd_pop     (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_seat    (out_seat),
		.out_verdict (m_tuser),
		.out_last    (m_tlast),
		.status      (status)
	);

	assign m_tdata = {{(DATA_W - SEAT_W){1'b0}}, out_seat};

	`RRPA_ASSERT_IMP(a_refuse_needs_term, m_tvalid && (m_tuser == VERDICT_REFUSE), status.terminated, "refusal shown while not terminated")
	`RRPA_ASSERT_IMP(a_walk_needs_term, status.terminating, status.terminated, "terminate walk without terminated flag")
	`RRPA_ASSERT_NXT(a_scan_no_growth, status.scanning, status.wait_count <= $past(status.wait_count), "wait queue grew during release scan")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the ring resource pair arbiter: directed and random seat traffic checked against a predictor.
module tb_top;
	import rrpa_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int RING_MAX     = 8;
	localparam int DRAIN_CYCLES = 24;
	localparam int PHASE_ITEMS  = 36;

	typedef struct packed {
		logic [SEAT_W-1:0] seat;
		logic              verdict;
		logic              last;
	} decision_t;

	class arbiter_scoreboard;
		logic [CNT_W-1:0] seat_count;
		bit res_busy[RING_MAX];
		bit holds[RING_MAX];
		int waiters[$];
		bit stopped;
		decision_t decisions[$];
		int errors;

		function new();
			seat_count = RESET_SEATS;
			errors = 0;
			clear();
		endfunction

		function void clear();
			for (int i = 0; i < RING_MAX; i++) begin
				res_busy[i] = 1'b0;
				holds[i] = 1'b0;
			end
			waiters.delete();
			stopped = 1'b0;
		endfunction

		function void note_config(logic [CNT_W-1:0] value);
			seat_count = value;
			clear();
		endfunction

		function int ring_size();
			int n;
			n = int'(seat_count);
			if (n < 2) n = 2;
			if (n > RING_MAX) n = RING_MAX;
			return n;
		endfunction

		function bit is_waiting(int s);
			foreach (waiters[i])
				if (waiters[i] == s) return 1'b1;
			return 1'b0;
		endfunction

		// Both resources must be free; then the front of the queue wins, or a seat whose two
		// ring neighbors are both waiting.
		function bit can_take(int s, int n);
			int right, left, near;
			right = (s + 1) % n;
			left = (s + n - 1) % n;
			near = 0;
			if (res_busy[s] || res_busy[right]) return 1'b0;
			if (waiters.size() > 0 && waiters[0] == s) return 1'b1;
			foreach (waiters[i])
				if (waiters[i] != s && (waiters[i] == right || waiters[i] == left)) near++;
			return near == 2;
		endfunction

		function void grab(int s, int n);
			res_busy[s] = 1'b1;
			res_busy[(s + 1) % n] = 1'b1;
			holds[s] = 1'b1;
		endfunction

		function void post(int s, logic verdict);
			decision_t d;
			d.seat = SEAT_W'(s);
			d.verdict = verdict;
			d.last = 1'b0;
			decisions = {decisions, d};
		endfunction

		function void note_input(logic [1:0] mode, logic [SEAT_W-1:0] seat_in);
			int n, s, i, start;
			decision_t d;
			n = ring_size();
			s = int'(seat_in);
			start = decisions.size();
			case (mode)
				MODE_REQUEST: begin
					if (s < n && !holds[s] && !is_waiting(s)) begin
						if (stopped) begin
							post(s, VERDICT_REFUSE);
						end else if (waiters.size() < RING_MAX) begin
							waiters = {waiters, s};
							if (can_take(s, n)) begin
								waiters.delete(waiters.size() - 1);
								grab(s, n);
								post(s, VERDICT_GRANT);
							end
						end
					end
				end
				MODE_RELEASE: begin
					if (s < n && holds[s]) begin
						holds[s] = 1'b0;
						res_busy[s] = 1'b0;
						res_busy[(s + 1) % n] = 1'b0;
						i = 0;
						// One pass in queue order; each grant is visible to later checks.
						while (!stopped && i < waiters.size()) begin
							if (can_take(waiters[i], n)) begin
								s = waiters[i];
								waiters.delete(i);
								grab(s, n);
								post(s, VERDICT_GRANT);
							end else begin
								i++;
							end
						end
					end
				end
				MODE_TERMINATE: begin
					stopped = 1'b1;
					foreach (waiters[j])
						post(waiters[j], VERDICT_REFUSE);
					waiters.delete();
				end
				default: ;
			endcase
			if (decisions.size() > start) begin
				d = decisions.pop_back();
				d.last = 1'b1;
				decisions = {decisions, d};
			end
		endfunction

		function int pending();
			return decisions.size();
		endfunction

		task report(string what, decision_t got, decision_t want);
			$display("mismatch (%s): got seat %0d verdict %0d last %0d, want seat %0d verdict %0d last %0d",
				what, got.seat, got.verdict, got.last, want.seat, want.verdict, want.last);
			errors++;
		endtask

		task check_result(decision_t got);
			decision_t want;
			if (decisions.size() == 0) begin
				report("unexpected result", got, '0);
			end else begin
				want = decisions.pop_front();
				if (got.seat !== want.seat || got.verdict !== want.verdict || got.last !== want.last)
					report("wrong field", got, want);
			end
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CNT_W-1:0]  cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata = '0;
	logic [1:0]        s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic              m_tuser;
	logic              m_tlast;

	arbiter_scoreboard sb = new();
	bit idle_on = 1'b1;
	int stall_left = 0;

	ring_resource_pair_arbiter #(.MAX_SEATS(RING_MAX)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	// Result side: check each accepted item, then decide whether to stall for a burst.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result('{seat: m_tdata[SEAT_W-1:0], verdict: m_tuser, last: m_tlast});
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 5) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task send_item(logic [1:0] mode, logic [SEAT_W-1:0] seat);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {{(DATA_W - SEAT_W){1'b0}}, seat};
		do @(posedge clk); while (!s_tready);
		sb.note_input(mode, seat);
	endtask

	// A release that grants nothing gives no sign of finishing, so keep draining after the predicted results are all seen.
	task settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_seat_count(logic [CNT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.note_config(value);
	endtask

	task random_item(int done);
		int n, r, pick;
		int holders[$];
		n = sb.ring_size();
		for (int i = 0; i < n; i++)
			if (sb.holds[i]) holders = {holders, i};
		r = $urandom_range(0, 99);
		if (r < 50 || (r < 82 && holders.size() == 0)) begin
			send_item(MODE_REQUEST, SEAT_W'($urandom_range(0, n - 1)));
		end else if (r < 82) begin
			pick = holders[$urandom_range(0, holders.size() - 1)];
			send_item(MODE_RELEASE, SEAT_W'(pick));
		end else if (r < 86 && done > 25) begin
			send_item(MODE_TERMINATE, SEAT_W'($urandom_range(0, 7)));
		end else begin
			send_item(2'($urandom_range(0, 3)), SEAT_W'($urandom_range(0, 7)));
		end
	endtask

	initial begin
		logic [CNT_W-1:0] counts[10];
		counts = '{4'd2, 4'd8, 4'd0, 4'd3, 4'd15, 4'd6, 4'd4, 4'd7, 4'd5, 4'd8};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Five seats after reset: front grants, a neighbor grant, ignored items, terminate.
		send_item(MODE_REQUEST, 0);
		send_item(MODE_REQUEST, 1);
		send_item(MODE_REQUEST, 4);
		send_item(MODE_REQUEST, 3);
		send_item(MODE_REQUEST, 2);
		send_item(MODE_REQUEST, 1);
		send_item(MODE_RELEASE, 3);
		send_item(MODE_REQUEST, 5);
		send_item(MODE_RELEASE, 7);
		send_item(MODE_UNUSED, 0);
		send_item(MODE_RELEASE, 0);
		send_item(MODE_RELEASE, 2);
		send_item(MODE_TERMINATE, 0);
		send_item(MODE_REQUEST, 3);
		send_item(MODE_REQUEST, 1);
		send_item(MODE_TERMINATE, 7);
		send_item(MODE_RELEASE, 1);
		send_item(MODE_RELEASE, 4);
		settle();

		// Two seats share one neighbor, so only the front rule applies.
		write_seat_count(MIN_RING);
		send_item(MODE_REQUEST, 0);
		send_item(MODE_REQUEST, 1);
		send_item(MODE_RELEASE, 0);
		send_item(MODE_REQUEST, 2);

		for (int p = 0; p < 10; p++) begin
			settle();
			write_seat_count(counts[p]);
			if (p == 9) idle_on = 1'b0;
			for (int k = 0; k < PHASE_ITEMS; k++)
				random_item(k);
		end

		settle();
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== ring_resource_pair_arbiter.f =====
+incdir+design
design/rrpa_pkg.sv
design/rrpa_front.sv
design/rrpa_cmd_fifo.sv
design/rrpa_back.sv
design/ring_resource_pair_arbiter.sv
bench/tb_top.sv
